@@ src/lpc_pkg.sv @@
// Shared types and constants for the LRU page cache with dirty bits.
package lpc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int AGE_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int FILE_BITS = 16;
  localparam int KEY_BITS  = 32;
  localparam int PAGE_BITS = 32;
  localparam int OP_W      = 3;
  localparam int CAP_W     = 5;
  localparam int IN_W      = 88;
  localparam int OUT_W     = 128;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_REMOVE = 3'd2,
    OP_EXISTS = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  // One stored entry
  typedef struct packed {
    logic [FILE_BITS-1:0] file;
    logic [KEY_BITS-1:0]  key;
    logic [PAGE_BITS-1:0] page;
    logic                 dirty;
    logic [AGE_W-1:0]     age;
  } entry_t;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]     entry_count;
    logic                 status;
    logic                 evicted_dirty;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [KEY_BITS-1:0]  evicted_key;
    logic [FILE_BITS-1:0] evicted_file;
    logic                 evicted;
    logic [PAGE_BITS-1:0] page_out;
    logic                 hit;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

@@ src/lru_page_cache_with_dirty_bits_core.sv @@
// Top level of the LRU page cache with dirty bits.
// Fully associative cache of 16 entries held in one synchronous memory. A
// sequencer handles each item by sweeping the memory one entry per cycle.
// Every item takes a search sweep, a decode state and a load state. Insert,
// lookup hits and remove hits add an update sweep and a finish state. List
// dirty repeats a selection sweep and load for each reported entry. A result
// that waits on m_axis_tready holds the sequencer in its load state, and a
// new item is taken only back in idle, once the last result is loaded. The
// sweeps follow from the memory's single read port.
// Capacity sits at byte address 0 of the register port; 0 acts as 1 and
// values above 16 act as 16.
module lru_page_cache_with_dirty_bits_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input items
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: file_id, page_key, page_id, dirty_in, zero fill
  input  logic [lpc_pkg::IN_W-1:0]    s_axis_tdata,
  // tuser: operation
  input  logic [lpc_pkg::OP_W-1:0]    s_axis_tuser,
  // result items
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: hit, page_out, evicted, evicted_file, evicted_key, evicted_page,
  //        evicted_dirty, status, entry_count, zero fill
  output logic [lpc_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                        m_axis_tlast
);

  localparam int FK_W = lpc_pkg::FILE_BITS + lpc_pkg::KEY_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIND, ST_DEC, ST_UPD, ST_FIN, ST_DSCAN, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    M_REFRESH, M_NEW, M_DROP
  } mode_e;

  state_e state_q;
  mode_e  mode_q;

  logic [lpc_pkg::CAP_W-1:0] capacity_q;
  logic [lpc_pkg::CAP_W-1:0] cap_eff;

  // entry memory and its read pipe
  lpc_pkg::entry_t mem [lpc_pkg::ENTRIES];
  lpc_pkg::entry_t rd_q;
  lpc_pkg::entry_t wd;
  logic            re, we;
  logic [lpc_pkg::IDX_W-1:0] ra_q;
  logic            rv_q;
  logic [lpc_pkg::CNT_W-1:0] cnt_q;
  logic            scan_done;
  logic            rd_valid;

  logic [lpc_pkg::ENTRIES-1:0] valid_q;
  logic [lpc_pkg::CNT_W-1:0]   count_q;

  // item fields
  lpc_pkg::op_e                  op_q;
  logic [lpc_pkg::FILE_BITS-1:0] f_q;
  logic [lpc_pkg::KEY_BITS-1:0]  k_q;
  logic [lpc_pkg::PAGE_BITS-1:0] p_q;
  logic                          d_q;

  // search results
  logic                          hit_q;
  logic [lpc_pkg::IDX_W-1:0]     s_idx_q;
  logic [lpc_pkg::AGE_W-1:0]     s_age_q;
  logic [lpc_pkg::PAGE_BITS-1:0] s_page_q;
  logic                          of_q;
  logic [lpc_pkg::IDX_W-1:0]     old_idx_q;
  lpc_pkg::entry_t               old_q;
  logic [lpc_pkg::CNT_W-1:0]     dcount_q;
  logic [lpc_pkg::IDX_W-1:0]     free_q;

  // oldest after refresh
  logic                          tr_q;
  logic [lpc_pkg::IDX_W-1:0]     tr_idx_q;
  lpc_pkg::entry_t               tr_e_q;

  // dirty listing
  logic                          have_last_q;
  logic [FK_W-1:0]               last_fk_q;
  logic                          bf_q;
  lpc_pkg::entry_t               best_q;
  logic [lpc_pkg::CNT_W-1:0]     emit_q;

  lpc_pkg::result_t              res_q;
  logic                          res_last_q;
  lpc_pkg::result_t              out_q;
  logic                          out_valid_q;
  logic                          out_last_q;
  logic                          out_free;
  logic                          out_load;
  lpc_pkg::result_t              res_fill;
  lpc_pkg::result_t              list_res;

  logic                          in_acc;
  logic [lpc_pkg::ENTRIES-1:0]   v_after;
  logic                          free_ok;
  logic [lpc_pkg::IDX_W-1:0]     free_idx;
  logic                          miss_evict;
  logic                          rd_v;
  logic [FK_W-1:0]               rd_fk;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {{(32-lpc_pkg::CAP_W){1'b0}}, capacity_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lpc_pkg::CAP_W'(lpc_pkg::ENTRIES);
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      capacity_q <= pwdata[lpc_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = lpc_pkg::CAP_W'(1);
    end else if (capacity_q > lpc_pkg::CAP_W'(lpc_pkg::ENTRIES)) begin
      cap_eff = lpc_pkg::CAP_W'(lpc_pkg::ENTRIES);
    end else begin
      cap_eff = capacity_q;
    end
  end

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = (state_q == ST_OUT) && out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lpc_pkg::OUT_W-lpc_pkg::RES_W){1'b0}}, out_q};
  assign m_axis_tlast  = out_last_q;

  // result as loaded, with the entry count after the operation
  always_comb begin
    res_fill             = res_q;
    res_fill.entry_count = count_q;
  end

  // one listed dirty entry
  always_comb begin
    list_res              = '0;
    list_res.hit          = 1'b1;
    list_res.page_out     = best_q.page;
    list_res.evicted_file = best_q.file;
    list_res.evicted_key  = best_q.key;
  end

  // sweep control: issue one read per cycle, data is registered and returns in the following cycle
  assign re        = (state_q == ST_FIND || state_q == ST_UPD || state_q == ST_DSCAN)
                     && cnt_q < lpc_pkg::CNT_W'(lpc_pkg::ENTRIES);
  assign scan_done = (cnt_q == lpc_pkg::CNT_W'(lpc_pkg::ENTRIES)) && !rv_q;
  assign rd_valid  = rv_q;
  assign rd_v      = valid_q[ra_q];
  assign rd_fk     = {rd_q.file, rd_q.key};
  assign we        = rd_valid && (state_q == ST_UPD);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[ra_q] <= wd;
    end
    if (re) begin
      rd_q <= mem[cnt_q[lpc_pkg::IDX_W-1:0]];
    end
  end

  // modified entry for the update sweep
  always_comb begin
    wd = rd_q;
    case (mode_q)
      M_REFRESH: begin
        if (ra_q == s_idx_q) begin
          wd.age   = '0;
          wd.dirty = rd_q.dirty | ((op_q == lpc_pkg::OP_INSERT) & d_q);
        end else if (rd_v && rd_q.age < s_age_q) begin
          wd.age = rd_q.age + 1'b1;
        end
      end
      M_NEW: begin
        if (ra_q == free_q) begin
          wd.file  = f_q;
          wd.key   = k_q;
          wd.page  = p_q;
          wd.dirty = d_q;
          wd.age   = '0;
        end else if (rd_v) begin
          wd.age = rd_q.age + 1'b1;
        end
      end
      M_DROP: begin
        if (rd_v && rd_q.age > s_age_q) begin
          wd.age = rd_q.age - 1'b1;
        end
      end
      default: wd = rd_q;
    endcase
  end

  // lowest free slot once a miss eviction is applied
  always_comb begin
    miss_evict = ({1'b0, count_q} + 1'b1) > {1'b0, cap_eff} && of_q;
    v_after    = valid_q;
    if (miss_evict) begin
      v_after[old_idx_q] = 1'b0;
    end
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = lpc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!v_after[i]) begin
        free_ok  = 1'b1;
        free_idx = lpc_pkg::IDX_W'(i);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= M_REFRESH;
      valid_q     <= '0;
      count_q     <= '0;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      ra_q        <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_q       <= '0;
    end else begin
      // read pipe
      rv_q <= re;
      if (re) begin
        ra_q  <= cnt_q[lpc_pkg::IDX_W-1:0];
        cnt_q <= cnt_q + 1'b1;
      end
      // load a new result or drop a taken one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q        <= lpc_pkg::op_e'(s_axis_tuser);
            f_q         <= s_axis_tdata[15:0];
            k_q         <= s_axis_tdata[47:16];
            p_q         <= s_axis_tdata[79:48];
            d_q         <= s_axis_tdata[80];
            res_q       <= '0;
            res_last_q  <= 1'b1;
            hit_q       <= 1'b0;
            of_q        <= 1'b0;
            tr_q        <= 1'b0;
            dcount_q    <= '0;
            have_last_q <= 1'b0;
            bf_q        <= 1'b0;
            emit_q      <= '0;
            cnt_q       <= '0;
            state_q     <= ST_FIND;
          end
        end

        ST_FIND: begin
          if (rd_valid && rd_v) begin
            if (rd_q.file == f_q && rd_q.key == k_q) begin
              hit_q    <= 1'b1;
              s_idx_q  <= ra_q;
              s_age_q  <= rd_q.age;
              s_page_q <= rd_q.page;
            end
            if (!of_q || rd_q.age > old_q.age) begin
              of_q      <= 1'b1;
              old_idx_q <= ra_q;
              old_q     <= rd_q;
            end
            if (rd_q.dirty) begin
              dcount_q <= dcount_q + 1'b1;
            end
          end
          if (scan_done) begin
            state_q <= ST_DEC;
          end
        end

        ST_DEC: begin
          cnt_q <= '0;
          case (op_q)
            lpc_pkg::OP_INSERT: begin
              res_q.hit <= hit_q;
              if (hit_q) begin
                mode_q  <= M_REFRESH;
                state_q <= ST_UPD;
              end else begin
                if (miss_evict) begin
                  valid_q[old_idx_q]  <= 1'b0;
                  count_q             <= count_q - 1'b1;
                  res_q.evicted       <= 1'b1;
                  res_q.evicted_file  <= old_q.file;
                  res_q.evicted_key   <= old_q.key;
                  res_q.evicted_page  <= old_q.page;
                  res_q.evicted_dirty <= old_q.dirty;
                end
                res_q.status <= !miss_evict;
                if (free_ok) begin
                  free_q  <= free_idx;
                  mode_q  <= M_NEW;
                  state_q <= ST_UPD;
                end else begin
                  state_q <= ST_OUT;
                end
              end
            end
            lpc_pkg::OP_LOOKUP: begin
              res_q.hit <= hit_q;
              if (hit_q) begin
                res_q.page_out <= s_page_q;
                mode_q         <= M_REFRESH;
                state_q        <= ST_UPD;
              end else begin
                res_q.status <= 1'b1;
                state_q      <= ST_OUT;
              end
            end
            lpc_pkg::OP_REMOVE: begin
              res_q.hit <= hit_q;
              if (hit_q) begin
                mode_q  <= M_DROP;
                state_q <= ST_UPD;
              end else begin
                state_q <= ST_OUT;
              end
            end
            lpc_pkg::OP_EXISTS: begin
              res_q.hit <= hit_q;
              state_q   <= ST_OUT;
            end
            lpc_pkg::OP_LIST: begin
              if (dcount_q != '0) begin
                state_q <= ST_DSCAN;
              end else begin
                state_q <= ST_OUT;
              end
            end
            default: state_q <= ST_OUT;
          endcase
        end

        ST_UPD: begin
          if (rd_valid && mode_q == M_REFRESH && rd_v) begin
            if (!tr_q || wd.age > tr_e_q.age) begin
              tr_q     <= 1'b1;
              tr_idx_q <= ra_q;
              tr_e_q   <= wd;
            end
          end
          if (scan_done) begin
            state_q <= ST_FIN;
          end
        end

        ST_FIN: begin
          state_q <= ST_OUT;
          case (mode_q)
            M_NEW: begin
              valid_q[free_q] <= 1'b1;
              count_q         <= count_q + 1'b1;
            end
            M_DROP: begin
              valid_q[s_idx_q] <= 1'b0;
              count_q          <= count_q - 1'b1;
            end
            M_REFRESH: begin
              if (op_q == lpc_pkg::OP_INSERT) begin
                if (count_q > cap_eff && tr_q) begin
                  valid_q[tr_idx_q]   <= 1'b0;
                  count_q             <= count_q - 1'b1;
                  res_q.evicted       <= 1'b1;
                  res_q.evicted_file  <= tr_e_q.file;
                  res_q.evicted_key   <= tr_e_q.key;
                  res_q.evicted_page  <= tr_e_q.page;
                  res_q.evicted_dirty <= tr_e_q.dirty;
                  res_q.status        <= 1'b0;
                end else begin
                  res_q.status <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end

        ST_DSCAN: begin
          // pick the smallest dirty key above the one reported last
          if (rd_valid && rd_v && rd_q.dirty && (!have_last_q || rd_fk > last_fk_q)) begin
            if (!bf_q || rd_fk < {best_q.file, best_q.key}) begin
              bf_q   <= 1'b1;
              best_q <= rd_q;
            end
          end
          if (scan_done) begin
            res_q       <= list_res;
            res_last_q  <= (emit_q + 1'b1) == dcount_q;
            emit_q      <= emit_q + 1'b1;
            last_fk_q   <= {best_q.file, best_q.key};
            have_last_q <= 1'b1;
            state_q     <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (out_free) begin
            out_q      <= res_fill;
            out_last_q <= res_last_q;
            if (res_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              bf_q    <= 1'b0;
              cnt_q   <= '0;
              state_q <= ST_DSCAN;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/lpc_checker.sv @@
// Port-level checks for the LRU page cache, bound to the top level.
module lpc_port_checks (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      pready,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [lpc_pkg::OUT_W-1:0] m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // busy right after an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while busy");

  // entry count never above the entry total
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[120:116] <= 5'd16)
    else $error("entry count out of range");

  // register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind lru_page_cache_with_dirty_bits_core lpc_port_checks u_lpc_port_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/lpc_checker.sv @@
// Checker for the LRU page cache: watches the channels, predicts and compares.
`timescale 1ns / 1ps
module lpc_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [lpc_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic [lpc_pkg::OP_W-1:0]  s_axis_tuser,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [lpc_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      m_axis_tlast,
  output int                        fail_count,
  output int                        pending_count
);
  import lpc_pkg::*;

  typedef struct packed {
    logic             last;
    result_t          res;
  } cache_reply_t;

  localparam int CAP_ADDR = 0;

  logic [CAP_W-1:0]     cap_reg;
  logic                 ent_valid [ENTRIES];
  logic [FILE_BITS-1:0] ent_file  [ENTRIES];
  logic [KEY_BITS-1:0]  ent_key   [ENTRIES];
  logic [PAGE_BITS-1:0] ent_page  [ENTRIES];
  logic                 ent_dirty [ENTRIES];
  int                   ent_age   [ENTRIES];
  int                   live_count;
  cache_reply_t         reply_q[$];

  assign pending_count = reply_q.size();

  function automatic int find_slot(logic [FILE_BITS-1:0] f, logic [KEY_BITS-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_file[i] == f && ent_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void touch_slot(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_age[i] < ent_age[s]) ent_age[i]++;
    ent_age[s] = 0;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_age[i] > ent_age[s]) ent_age[i]--;
    ent_valid[s] = 1'b0;
    live_count--;
  endfunction

  function automatic void evict_lru(ref result_t r);
    int s;
    s = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && (s < 0 || ent_age[i] > ent_age[s])) s = i;
    if (s < 0) return;
    r.evicted       = 1'b1;
    r.evicted_file  = ent_file[s];
    r.evicted_key   = ent_key[s];
    r.evicted_page  = ent_page[s];
    r.evicted_dirty = ent_dirty[s];
    drop_slot(s);
  endfunction

  // Apply one item to the cache image and queue the replies it causes
  function automatic void predict_cache_op(logic [OP_W-1:0] op, logic [IN_W-1:0] d);
    logic [FILE_BITS-1:0] f;
    logic [KEY_BITS-1:0]  k;
    logic [PAGE_BITS-1:0] p;
    logic                 dn;
    int                   cap, s, fr;
    int                   order[$];
    result_t              r;
    cache_reply_t         c;
    f  = d[15:0];
    k  = d[47:16];
    p  = d[79:48];
    dn = d[80];
    cap = cap_reg;
    if (cap < 1) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    s = find_slot(f, k);
    r = '0;
    case (op)
      OP_INSERT: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          if (dn) ent_dirty[s] = 1'b1;
          touch_slot(s);
          if (live_count > cap) evict_lru(r);
        end else begin
          if (live_count + 1 > cap) evict_lru(r);
          fr = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (!ent_valid[i] && fr < 0) fr = i;
          if (fr >= 0) begin
            for (int j = 0; j < ENTRIES; j++)
              if (ent_valid[j]) ent_age[j]++;
            ent_valid[fr] = 1'b1;
            ent_file[fr]  = f;
            ent_key[fr]   = k;
            ent_page[fr]  = p;
            ent_dirty[fr] = dn;
            ent_age[fr]   = 0;
            live_count++;
          end
        end
        r.status = !r.evicted;
      end
      OP_LOOKUP: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          r.page_out = ent_page[s];
          touch_slot(s);
        end else begin
          r.status = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          drop_slot(s);
        end
      end
      OP_EXISTS: r.hit = (s >= 0);
      OP_LIST: begin
        for (int i = 0; i < ENTRIES; i++)
          if (ent_valid[i] && ent_dirty[i]) order = {order, i};
        order.sort() with ({ent_file[item], ent_key[item]});
        foreach (order[a]) begin
          c = '0;
          c.res.hit          = 1'b1;
          c.res.page_out     = ent_page[order[a]];
          c.res.evicted_file = ent_file[order[a]];
          c.res.evicted_key  = ent_key[order[a]];
          c.res.entry_count  = CNT_W'(live_count);
          c.last             = (a == order.size() - 1);
          reply_q = {reply_q, c};
        end
        if (order.size() > 0) return;
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(live_count);
    c.res  = r;
    c.last = 1'b1;
    reply_q = {reply_q, c};
  endfunction

  // Track register writes, predict on each input item, compare each result item
  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t got, want;
    if (!rst_ni) begin
      cap_reg    = 5'd16;
      live_count = 0;
      fail_count = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        ent_valid[i] = 1'b0;
        ent_age[i]   = 0;
      end
      reply_q.delete();
    end else begin
      if (psel && penable && pwrite && paddr == CAP_ADDR) cap_reg = pwdata[CAP_W-1:0];
      if (m_axis_tvalid && m_axis_tready) begin
        got.res  = result_t'(m_axis_tdata[RES_W-1:0]);
        got.last = m_axis_tlast;
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item %h", got);
        end else begin
          want = reply_q.pop_front();
          if (got !== want || m_axis_tdata[OUT_W-1:RES_W] !== '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p last %b, got %p last %b",
                       want.res, want.last, got.res, got.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_cache_op(s_axis_tuser, s_axis_tdata);
    end
  end
endmodule

@@ dv/tb_lru_page_cache_with_dirty_bits_core.sv @@
// Testbench top for the LRU page cache: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_lru_page_cache_with_dirty_bits_core;
  import lpc_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;
  int                   fail_count, pending_count;
  int                   out_wait = 3;
  logic [FILE_BITS-1:0] file_pool [4];
  logic [KEY_BITS-1:0]  key_pool  [4];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lru_page_cache_with_dirty_bits_core DUT (.*);

  lpc_checker u_checker (.*);

  // Hold tready low for a random wait, possibly none, before each result item
  always @(posedge clk_i) begin
    int w;
    if (m_axis_tvalid && m_axis_tready) begin
      w = $urandom_range(0, 13);
      out_wait      <= w;
      m_axis_tready <= (w == 0);
    end else if (out_wait > 0) begin
      out_wait      <= out_wait - 1;
      m_axis_tready <= (out_wait == 1);
    end
  end

  task automatic write_capacity(int unsigned v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drop the input, then wait until all replies are in and the block is idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic send_item(op_e op, logic [15:0] f, logic [31:0] k, logic [31:0] p,
                           logic dn);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, dn, p, k, f};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random(int n);
    int r;
    op_e op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      op = (r < 4) ? OP_INSERT : (r < 6) ? OP_LOOKUP : (r < 7) ? OP_REMOVE :
           (r < 8) ? OP_EXISTS : (r < 9) ? OP_LIST : op_e'($urandom_range(5, 7));
      send_item(op, file_pool[$urandom_range(0, 3)],
                ($urandom_range(0, 15) == 0) ? $urandom : key_pool[$urandom_range(0, 3)],
                $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    file_pool = '{16'h0000, 16'hFFFF, FILE_BITS'($urandom), FILE_BITS'($urandom)};
    key_pool  = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_capacity(2);
    // Directed: extremes, every operation, hit and miss paths
    send_item(OP_LIST,   0, 0, 0, 0);
    send_item(OP_LOOKUP, 0, 0, 0, 0);
    send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_item(OP_INSERT, 0, 0, 32'h1234_5678, 0);
    send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
    send_item(OP_INSERT, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555, 1);
    send_item(OP_LOOKUP, 16'h5555, 32'hAAAA_AAAA, 0, 0);
    send_item(OP_EXISTS, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
    send_item(OP_EXISTS, 16'h5555, 32'hAAAA_AAAA, 0, 0);
    send_item(OP_LIST,   0, 0, 0, 0);
    send_item(OP_INSERT, 0, 0, 0, 1);
    send_item(OP_REMOVE, 0, 0, 0, 0);
    send_item(OP_REMOVE, 0, 0, 0, 0);
    send_item(op_e'(3'd7), 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    wait_idle();
    // Capacity of 0 acts as 1, and dropping below the count evicts on insert
    write_capacity(0);
    send_item(OP_INSERT, 16'h5555, 32'hAAAA_AAAA, 0, 0);
    send_item(OP_INSERT, 1, 1, 1, 1);
    wait_idle();
    write_capacity(31);
    send_random(35);
    wait_idle();
    write_capacity(3);
    send_random(35);
    wait_idle();
    write_capacity(16);
    send_random(24);
    wait_idle();
    if (fail_count == 0 && pending_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
